// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker module of the hash block.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/sha256h_pkg.sv -----
// Package for the SHA-256 hasher: sequencer states, round constants, initial hash.
// No dependencies; used by sha256_hasher_unit and sha256h_checker.
package sha256h_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_HADD,
        ST_PAD,
        ST_OUT
    } sha256h_state_t;

    localparam int unsigned DIGEST_WORDS = 8;
    localparam logic [2:0]  WORD_IDX_LAST = 3'd7;
    localparam logic [5:0]  ROUND_LAST = 6'd63;
    localparam logic [5:0]  LEN_OFFSET = 6'd56;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [31:0] HASH_IV [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// ----- hw/rtl/sha256_hasher_unit.sv -----
// SHA-256 hasher top level: byte intake, padding sequencer and one-round-per-cycle
// compression unit. Depends on sha256h_pkg.
//
// Streaming SHA-256 (FIPS 180-4). Each input beat carries at most one message
// byte (s_byte_present) and may close the message (s_end_of_message, applied
// after the byte it carries). A beat is taken whenever s_valid and s_ready are
// both high. Bytes gather in a 512-bit shift line that doubles as the rolling
// message schedule; when 64 bytes are held, s_ready drops and one shared round
// unit runs the 64 compression rounds, one per cycle, followed by a hash-add
// step that folds the working variables into the hash. Closing a message adds
// the padding: the sequencer pushes the 0x80 byte, zeros and the 64-bit
// big-endian bit length (9 to 72 bytes) one byte per cycle, pausing while a
// full block is compressed; this fills one or two final blocks that are
// compressed as above. The eight digest words then leave on the m_ channel,
// word 0 (most significant) first, m_last_word on word 7, one per accepted
// beat; s_ready stays low until the last word is taken, and the hash then
// returns to its initial value for the next message. The bit length wraps
// modulo 2^64. An input beat with neither a byte nor an end mark does nothing.
// No clearing pass is needed after reset.
module sha256_hasher_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_byte_present,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);
    import sha256h_pkg::*;

    // Rotate-right helpers for the round and schedule functions.
    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    sha256h_state_t state_reg, state_next;

    // Block buffer and message schedule: word k sits at [511-32k -: 32].
    logic [511:0] buf_reg, buf_next;
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  length_reg, length_next;
    logic [5:0]   round_reg, round_next;
    logic [2:0]   word_idx_reg, word_idx_next;
    logic         eom_pend_reg, eom_pend_next;   // message closed, padding owed
    logic         sent80_reg, sent80_next;       // 0x80 byte already pushed
    logic         wrap_reg, wrap_next;           // length goes in the next block
    logic         last_blk_reg, last_blk_next;   // block in flight ends the message
    logic [31:0]  hash_reg [DIGEST_WORDS];
    logic [31:0]  hash_next [DIGEST_WORDS];
    logic [31:0]  work_reg [DIGEST_WORDS];
    logic [31:0]  work_next [DIGEST_WORDS];

    logic         push_en;
    logic [7:0]   push_byte;
    logic [6:0]   fill_inc;
    logic         fill_full;
    logic [63:0]  len_bits;
    logic [7:0]   len_byte;

    logic [31:0]  t1, t2, w_new;

    assign fill_inc  = {1'b0, fill_reg} + 7'd1;
    assign fill_full = fill_inc[6];
    assign len_bits  = {length_reg[60:0], 3'b000};
    assign len_byte  = 8'(len_bits >> {~fill_reg[2:0], 3'b000});

    // Shared round unit: one SHA-256 round plus one schedule word per cycle.
    assign t1 = work_reg[7] + big_sigma1(work_reg[4])
              + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
              + ROUND_K[round_reg] + buf_reg[511:480];
    assign t2 = big_sigma0(work_reg[0])
              + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                 ^ (work_reg[1] & work_reg[2]));
    assign w_new = small_sigma1(buf_reg[63:32]) + buf_reg[223:192]
                 + small_sigma0(buf_reg[479:448]) + buf_reg[511:480];

    always_comb begin
        state_next    = state_reg;
        buf_next      = buf_reg;
        fill_next     = fill_reg;
        length_next   = length_reg;
        round_next    = round_reg;
        word_idx_next = word_idx_reg;
        eom_pend_next = eom_pend_reg;
        sent80_next   = sent80_reg;
        wrap_next     = wrap_reg;
        last_blk_next = last_blk_reg;
        hash_next     = hash_reg;
        work_next     = work_reg;
        push_en       = 1'b0;
        push_byte     = 8'd0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_byte_present) begin
                        push_en     = 1'b1;
                        push_byte   = s_byte_value;
                        length_next = length_reg + 64'd1;
                    end
                    eom_pend_next = s_end_of_message;
                    if (s_end_of_message) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                push_en = 1'b1;
                if (!sent80_reg) begin
                    push_byte   = PAD_BYTE;
                    sent80_next = 1'b1;
                    wrap_next   = (fill_reg >= LEN_OFFSET);
                end else if (fill_reg >= LEN_OFFSET && !wrap_reg) begin
                    push_byte = len_byte;
                end else begin
                    push_byte = 8'd0;
                end
                if (fill_full) begin
                    last_blk_next = sent80_next && !wrap_next;
                    wrap_next     = 1'b0;
                end
            end
            ST_ROUND: begin
                work_next[0] = t1 + t2;
                work_next[1] = work_reg[0];
                work_next[2] = work_reg[1];
                work_next[3] = work_reg[2];
                work_next[4] = work_reg[3] + t1;
                work_next[5] = work_reg[4];
                work_next[6] = work_reg[5];
                work_next[7] = work_reg[6];
                buf_next     = {buf_reg[479:0], w_new};
                round_next   = round_reg + 6'd1;
                if (round_reg == ROUND_LAST) begin
                    state_next = ST_HADD;
                end
            end
            ST_HADD: begin
                for (int i = 0; i < DIGEST_WORDS; i++) begin
                    hash_next[i] = hash_reg[i] + work_reg[i];
                end
                if (last_blk_reg) begin
                    state_next    = ST_OUT;
                    word_idx_next = 3'd0;
                end else if (eom_pend_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    word_idx_next = word_idx_reg + 3'd1;
                    if (word_idx_reg == WORD_IDX_LAST) begin
                        // Message done: restart from the initial hash.
                        hash_next     = HASH_IV;
                        fill_next     = 6'd0;
                        length_next   = 64'd0;
                        eom_pend_next = 1'b0;
                        sent80_next   = 1'b0;
                        wrap_next     = 1'b0;
                        last_blk_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Shift a byte into the block; a full block starts the compression.
        if (push_en) begin
            buf_next  = {buf_reg[503:0], push_byte};
            fill_next = fill_inc[5:0];
            if (fill_full) begin
                state_next = ST_ROUND;
                round_next = 6'd0;
                work_next  = hash_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= 6'd0;
            length_reg   <= 64'd0;
            round_reg    <= 6'd0;
            word_idx_reg <= 3'd0;
            eom_pend_reg <= 1'b0;
            sent80_reg   <= 1'b0;
            wrap_reg     <= 1'b0;
            last_blk_reg <= 1'b0;
            hash_reg     <= HASH_IV;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            length_reg   <= length_next;
            round_reg    <= round_next;
            word_idx_reg <= word_idx_next;
            eom_pend_reg <= eom_pend_next;
            sent80_reg   <= sent80_next;
            wrap_reg     <= wrap_next;
            last_blk_reg <= last_blk_next;
            hash_reg     <= hash_next;
        end
    end

    // Data path registers: no reset, every entry written before it is read.
    always_ff @(posedge aclk) begin
        buf_reg  <= buf_next;
        work_reg <= work_next;
    end

    // Output beats come straight from the hash and word index registers.
    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_OUT);
    assign m_digest_word = hash_reg[word_idx_reg];
    assign m_word_index  = word_idx_reg;
    assign m_last_word   = (word_idx_reg == WORD_IDX_LAST);

endmodule

// ----- hw/rtl/sha256h_checker.sv -----
// Port-level checker for sha256_hasher_unit, attached by bind.
// Depends on sha256h_pkg and assert_macros.svh.
module sha256h_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_byte_value,
    input logic        s_byte_present,
    input logic        s_end_of_message,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_digest_word,
    input logic [2:0]  m_word_index,
    input logic        m_last_word
);
    import sha256h_pkg::*;
    `include "assert_macros.svh"

    // Advance the word index by one after each non-final digest beat.
    `ASSERT_CLK_RST(a_idx_step, aclk, aresetn, m_valid && m_ready && !m_last_word |=> m_valid && (m_word_index == 3'($past(m_word_index) + 3'd1)), "digest word index did not advance")

    // Flag the final word exactly at the last index.
    `ASSERT_CLK_RST(a_last_flag, aclk, aresetn, m_valid |-> (m_last_word == (m_word_index == WORD_IDX_LAST)), "last_word does not match index")

    // Hold off input beats while a digest is being delivered.
    `ASSERT_CLK(a_no_overlap, aclk, m_valid |-> !s_ready, "input ready during digest output")

    // Start every digest at word 0.
    `ASSERT_CLK_RST(a_first_word, aclk, aresetn, m_valid && !$past(m_valid) |-> (m_word_index == 3'd0), "digest did not start at word 0")

    // Return to intake right after the final word is taken.
    `ASSERT_CLK_RST(a_resume, aclk, aresetn, m_valid && m_ready && m_last_word |=> s_ready && !m_valid, "block did not resume after digest")

endmodule

bind sha256_hasher_unit sha256h_checker u_sha256h_checker (.*);
